>>> sv/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_SAME(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> sv/tspq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tspq_pkg;

    typedef logic [1:0] t_status;

    localparam t_status STATUS_OK    = 2'd0;
    localparam t_status STATUS_EMPTY = 2'd1;
    localparam t_status STATUS_FULL  = 2'd2;

    typedef logic t_cmd;

    localparam t_cmd CMD_PUSH = 1'b0;
    localparam t_cmd CMD_POP  = 1'b1;

endpackage

`default_nettype wire

>>> sv/time_sorted_priority_queue_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Time-sorted priority queue. Entries (time, payload) are kept in ascending
// time order in a circular buffer of CAPACITY slots; equal times leave in
// arrival order.
// Input channel (i_in_valid / o_in_ready): i_cmd push (0) or pop (1),
// i_item_time and i_item_payload for a push. Output channel
// (o_out_valid / i_out_ready): one result item per input item with
// o_status (ok, pop on empty, push on full dropped), the popped entry or
// zeros, and o_is_empty after the operation.
// Steps: a pop reads the head slot, latches it in S_POP and goes to
// S_DONE; a rejected push and a push into an empty queue go straight to
// S_DONE; other pushes run the insertion scan in S_SCAN (one buffer read
// and one write per cycle, shifting each stored entry with a later time
// up by one slot, the last write placing the new entry, in S_PLACE when
// all were later), then S_DONE. The block takes one item at a time.
// A finished result sits in the output register; the next item is taken
// while it waits. A result that cannot be loaded because the receiver
// stalls holds the block until the output register frees up.
// Reset empties the queue at once; buffer contents are not cleared.
module time_sorted_priority_queue_unit #(
    parameter int CAPACITY     = 16,
    parameter int TIME_BITS    = 16,
    parameter int PAYLOAD_BITS = 32
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic                    i_cmd,
    input  wire logic [TIME_BITS-1:0]    i_item_time,
    input  wire logic [PAYLOAD_BITS-1:0] i_item_payload,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic [1:0]                   o_status,
    output logic [TIME_BITS-1:0]         o_out_time,
    output logic [PAYLOAD_BITS-1:0]      o_out_payload,
    output logic                         o_is_empty
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = CW + 1;

    localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);
    localparam logic [SW-1:0] CAP_WIDE = SW'(CAPACITY);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_POP   = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_PLACE = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]                r_state, n_state;
    logic [AW-1:0]             r_head, n_head;
    logic [AW-1:0]             r_tail, n_tail;
    logic [AW-1:0]             r_ptr, n_ptr;
    logic [AW-1:0]             r_k, n_k;
    logic [CW-1:0]             r_count, n_count;

    logic [TIME_BITS-1:0]      r_time, n_time;
    logic [PAYLOAD_BITS-1:0]   r_payload, n_payload;
    tspq_pkg::t_status         r_res_status, n_res_status;
    logic [TIME_BITS-1:0]      r_res_time, n_res_time;
    logic [PAYLOAD_BITS-1:0]   r_res_payload, n_res_payload;

    logic                      r_out_valid, n_out_valid;
    tspq_pkg::t_status         r_out_status;
    logic [TIME_BITS-1:0]      r_out_time;
    logic [PAYLOAD_BITS-1:0]   r_out_payload;
    logic                      r_out_empty;

    logic [TIME_BITS-1:0]      r_mem_time [CAPACITY];
    logic [PAYLOAD_BITS-1:0]   r_mem_payload [CAPACITY];
    logic [TIME_BITS-1:0]      r_rd_time;
    logic [PAYLOAD_BITS-1:0]   r_rd_payload;

    logic                      w_accept;
    logic                      w_load;
    logic                      w_we;
    logic [AW-1:0]             w_wa;
    logic [TIME_BITS-1:0]      w_wt;
    logic [PAYLOAD_BITS-1:0]   w_wp;
    logic                      w_re;
    logic [AW-1:0]             w_ra;
    logic [SW-1:0]             w_sum;
    logic [AW-1:0]             w_tail_calc;
    logic                      w_res_empty;
    logic                      w_res_fail;
    logic                      w_res_zero;
    logic                      w_scan_next;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
        return (p == '0) ? LAST_SLOT : p - AW'(1);
    endfunction

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_load     = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state       = r_state;
        n_head        = r_head;
        n_tail        = r_tail;
        n_ptr         = r_ptr;
        n_k           = r_k;
        n_count       = r_count;
        n_time        = r_time;
        n_payload     = r_payload;
        n_res_status  = r_res_status;
        n_res_time    = r_res_time;
        n_res_payload = r_res_payload;
        w_we          = 1'b0;
        w_wa          = r_tail;
        w_wt          = r_time;
        w_wp          = r_payload;
        w_re          = 1'b0;
        w_ra          = r_head;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_time        = i_item_time;
                    n_payload     = i_item_payload;
                    n_res_status  = tspq_pkg::STATUS_OK;
                    n_res_time    = '0;
                    n_res_payload = '0;
                    if (i_cmd == tspq_pkg::CMD_POP) begin
                        if (r_count == '0) begin
                            n_res_status = tspq_pkg::STATUS_EMPTY;
                            n_state      = S_DONE;
                        end else begin
                            w_re    = 1'b1;
                            w_ra    = r_head;
                            n_state = S_POP;
                        end
                    end else if (r_count == FULL_COUNT) begin
                        n_res_status = tspq_pkg::STATUS_FULL;
                        n_state      = S_DONE;
                    end else if (r_count == '0) begin
                        w_we    = 1'b1;
                        w_wa    = r_tail;
                        w_wt    = i_item_time;
                        w_wp    = i_item_payload;
                        n_tail  = ptr_inc(r_tail);
                        n_count = r_count + CW'(1);
                        n_state = S_DONE;
                    end else begin
                        w_re    = 1'b1;
                        w_ra    = ptr_dec(r_tail);
                        n_ptr   = ptr_dec(r_tail);
                        n_k     = AW'(r_count - CW'(1));
                        n_tail  = ptr_inc(r_tail);
                        n_count = r_count + CW'(1);
                        n_state = S_SCAN;
                    end
                end
            end
            S_POP: begin
                n_res_time    = r_rd_time;
                n_res_payload = r_rd_payload;
                n_head        = ptr_inc(r_head);
                n_count       = r_count - CW'(1);
                n_state       = S_DONE;
            end
            S_SCAN: begin
                w_we = 1'b1;
                w_wa = ptr_inc(r_ptr);
                if (r_rd_time > r_time) begin
                    w_wt = r_rd_time;
                    w_wp = r_rd_payload;
                    if (r_k == '0) begin
                        n_state = S_PLACE;
                    end else begin
                        w_re  = 1'b1;
                        w_ra  = ptr_dec(r_ptr);
                        n_ptr = ptr_dec(r_ptr);
                        n_k   = r_k - AW'(1);
                    end
                end else begin
                    n_state = S_DONE;
                end
            end
            S_PLACE: begin
                w_we    = 1'b1;
                w_wa    = r_ptr;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_ptr       <= '0;
            r_k         <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_ptr       <= n_ptr;
            r_k         <= n_k;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_time        <= n_time;
        r_payload     <= n_payload;
        r_res_status  <= n_res_status;
        r_res_time    <= n_res_time;
        r_res_payload <= n_res_payload;
        if (w_load) begin
            r_out_status  <= r_res_status;
            r_out_time    <= r_res_time;
            r_out_payload <= r_res_payload;
            r_out_empty   <= (r_count == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem_time[w_wa]    <= w_wt;
            r_mem_payload[w_wa] <= w_wp;
        end
        if (w_re) begin
            r_rd_time    <= r_mem_time[w_ra];
            r_rd_payload <= r_mem_payload[w_ra];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_out_time    = r_out_time;
    assign o_out_payload = r_out_payload;
    assign o_is_empty    = r_out_empty;

    assign w_sum       = SW'(r_head) + SW'(r_count);
    assign w_tail_calc = (w_sum >= CAP_WIDE) ? AW'(w_sum - CAP_WIDE) : AW'(w_sum);
    assign w_res_empty = o_out_valid && (o_status == tspq_pkg::STATUS_EMPTY);
    assign w_res_fail  = o_out_valid && (o_status != tspq_pkg::STATUS_OK);
    assign w_res_zero  = (o_out_time == '0) && (o_out_payload == '0);
    assign w_scan_next = (r_state == S_SCAN) || (r_state == S_PLACE) || (r_state == S_DONE);

`include "assert_macros.svh"

    `ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= FULL_COUNT)
    `ASSERT_SAME(a_tail_track, i_clk, i_rst_n, 1'b1, w_tail_calc == r_tail)
    `ASSERT_SAME(a_empty_flag, i_clk, i_rst_n, w_res_empty, o_is_empty)
    `ASSERT_SAME(a_zero_fail, i_clk, i_rst_n, w_res_fail, w_res_zero)
    `ASSERT_NEXT(a_scan_bound, i_clk, i_rst_n, r_state == S_SCAN, w_scan_next)

endmodule

`default_nettype wire
